// ----- rtl/aaedge_pkg.sv -----
package aaedge_pkg;

    // Default largest region side that the border test honors.
    localparam int MAX_DIM_DEF = 4096;

    // Field widths.
    localparam int POS_W    = 12;
    localparam int PIX_W    = 32;
    localparam int LUMA_W   = 8;
    localparam int SUM_W    = 10;
    localparam int FMT_W    = 3;
    localparam int DIM_REG_W = 13;
    localparam int THR_W    = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_THR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MARGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HARD_EDGE_TOL = 3'd5;

    // Pixel format codes.
    localparam logic [FMT_W-1:0] FMT_RGBA8888 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_BGRA8888 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_RGB565   = 3'd2;
    localparam logic [FMT_W-1:0] FMT_ARGB4444 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_GRAY8    = 3'd4;

    // Register reset values.
    localparam logic [THR_W-1:0] RST_BOUNDARY_THR  = 8'd10;
    localparam logic [THR_W-1:0] RST_BLEND_MARGIN  = 8'd2;
    localparam logic [THR_W-1:0] RST_HARD_EDGE_TOL = 8'd3;

    // Divide by three as (n * 683) >> 11, exact for n below 2048.
    localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
    localparam int               DIV3_SHIFT = 11;

    typedef struct packed {
        logic [FMT_W-1:0]     pixel_format;
        logic [DIM_REG_W-1:0] image_width;
        logic [DIM_REG_W-1:0] image_height;
        logic [THR_W-1:0]     edge_threshold;
        logic [THR_W-1:0]     inner_margin;
        logic [THR_W-1:0]     hard_edge_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] centre_pixel;
        logic [PIX_W-1:0] left_pixel;
        logic [PIX_W-1:0] right_pixel;
        logic [PIX_W-1:0] upper_pixel;
        logic [PIX_W-1:0] lower_pixel;
    } t_in;

    typedef struct packed {
        logic              is_blend_pixel;
        logic [LUMA_W-1:0] centre_luma;
    } t_out;

endpackage

// ----- rtl/aaedge_cfg.sv -----
module aaedge_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [aaedge_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aaedge_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                               o_cfg_ready,
    output aaedge_pkg::t_cfg                   o_cfg
);

    aaedge_pkg::t_cfg r_cfg;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format        <= aaedge_pkg::FMT_RGBA8888;
            r_cfg.image_width         <= '0;
            r_cfg.image_height        <= '0;
            r_cfg.edge_threshold      <= aaedge_pkg::RST_BOUNDARY_THR;
            r_cfg.inner_margin        <= aaedge_pkg::RST_BLEND_MARGIN;
            r_cfg.hard_edge_tolerance <= aaedge_pkg::RST_HARD_EDGE_TOL;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aaedge_pkg::REG_PIXEL_FORMAT: begin
                    r_cfg.pixel_format <= i_cfg_data[aaedge_pkg::FMT_W-1:0];
                end
                aaedge_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[aaedge_pkg::DIM_REG_W-1:0];
                end
                aaedge_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[aaedge_pkg::DIM_REG_W-1:0];
                end
                aaedge_pkg::REG_BOUNDARY_THR: begin
                    r_cfg.edge_threshold <= i_cfg_data[aaedge_pkg::THR_W-1:0];
                end
                aaedge_pkg::REG_BLEND_MARGIN: begin
                    r_cfg.inner_margin <= i_cfg_data[aaedge_pkg::THR_W-1:0];
                end
                aaedge_pkg::REG_HARD_EDGE_TOL: begin
                    r_cfg.hard_edge_tolerance <= i_cfg_data[aaedge_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/aaedge_luma.sv -----
module aaedge_luma (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [aaedge_pkg::FMT_W-1:0]     i_fmt,
    input  logic [aaedge_pkg::PIX_W-1:0]     i_word,
    output logic [aaedge_pkg::LUMA_W-1:0]    o_luma
);

    localparam int SW = aaedge_pkg::SUM_W;
    localparam int LW = aaedge_pkg::LUMA_W;
    localparam int PW = 2 * SW;

    logic [SW-1:0]                  n_sum;
    logic [SW-1:0]                  r_sum;
    logic [aaedge_pkg::FMT_W-1:0]   r_fmt;
    logic [LW-1:0]                  n_luma;
    logic [LW-1:0]                  r_luma;
    logic [PW-1:0]                  prod;
    logic [LW-1:0]                  quot;
    logic [LW-1:0]                  r8;
    logic [LW-1:0]                  g8;
    logic [LW-1:0]                  b8;

    // RGB565 channels widened to 8 bits by repeating their top bits.
    assign r8 = {i_word[15:11], i_word[15:13]};
    assign g8 = {i_word[10:5], i_word[10:9]};
    assign b8 = {i_word[4:0], i_word[4:2]};

    // First stage: unpack the channels and add them up.
    always_comb begin
        case (i_fmt) inside
            aaedge_pkg::FMT_RGBA8888, aaedge_pkg::FMT_BGRA8888: begin
                n_sum = SW'(i_word[7:0]) + SW'(i_word[15:8]) + SW'(i_word[23:16]);
            end
            aaedge_pkg::FMT_RGB565: begin
                n_sum = SW'(r8) + SW'(g8) + SW'(b8);
            end
            aaedge_pkg::FMT_ARGB4444: begin
                n_sum = SW'(i_word[15:12]) + SW'(i_word[11:8]) + SW'(i_word[7:4]);
            end
            aaedge_pkg::FMT_GRAY8: begin
                n_sum = SW'(i_word[7:0]);
            end
            default: begin
                n_sum = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            r_fmt <= i_fmt;
        end
    end

    // Second stage: divide by three through a reciprocal, then scale 4444; gray passes through.
    assign prod = r_sum * aaedge_pkg::DIV3_MUL;
    assign quot = prod[aaedge_pkg::DIV3_SHIFT +: LW];

    always_comb begin
        case (r_fmt) inside
            aaedge_pkg::FMT_RGBA8888, aaedge_pkg::FMT_BGRA8888,
            aaedge_pkg::FMT_RGB565: begin
                n_luma = quot;
            end
            aaedge_pkg::FMT_ARGB4444: begin
                n_luma = {quot[3:0], 4'b0000} + quot;
            end
            aaedge_pkg::FMT_GRAY8: begin
                n_luma = r_sum[LW-1:0];
            end
            default: begin
                n_luma = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma <= n_luma;
        end
    end

    assign o_luma = r_luma;

endmodule

// ----- rtl/aaedge_axis.sv -----
module aaedge_axis (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [aaedge_pkg::LUMA_W-1:0]   i_c,
    input  logic [aaedge_pkg::LUMA_W-1:0]   i_a,
    input  logic [aaedge_pkg::LUMA_W-1:0]   i_b,
    input  aaedge_pkg::t_cfg                i_cfg,
    output logic                            o_blend
);

    localparam int LW = aaedge_pkg::LUMA_W;

    logic [LW-1:0] mn;
    logic [LW-1:0] mx;
    logic [LW-1:0] d_ab;
    logic [LW-1:0] d_ca;
    logic [LW-1:0] d_cb;
    logic          r_bnd;
    logic          r_far_a;
    logic          r_far_b;
    logic [LW:0]   r_lo;
    logic [LW:0]   r_cm;
    logic [LW-1:0] r_mx;
    logic [LW-1:0] r_c;

    // Differences and range ends of the two opposite neighbors.
    assign mn   = (i_a < i_b) ? i_a : i_b;
    assign mx   = (i_a < i_b) ? i_b : i_a;
    assign d_ab = mx - mn;
    assign d_ca = (i_c > i_a) ? i_c - i_a : i_a - i_c;
    assign d_cb = (i_c > i_b) ? i_c - i_b : i_b - i_c;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bnd   <= d_ab > i_cfg.edge_threshold;
            r_far_a <= d_ca > i_cfg.hard_edge_tolerance;
            r_far_b <= d_cb > i_cfg.hard_edge_tolerance;
            r_lo    <= {1'b0, mn} + {1'b0, i_cfg.inner_margin};
            r_cm    <= {1'b0, i_c} + {1'b0, i_cfg.inner_margin};
            r_mx    <= mx;
            r_c     <= i_c;
        end
    end

    // The centre must clear both margined ends: c > min + m and c + m < max.
    assign o_blend = r_bnd && r_far_a && r_far_b
                     && ({1'b0, r_c} > r_lo) && (r_cm < {1'b0, r_mx});

endmodule

// ----- rtl/antialias_edge_pixel_detector.sv -----
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    i_in_data  (t_in)
// out       from block o_out_valid / i_out_stall  o_out_data (t_out)
// cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle while the output is not stalled; its result
// sits in the output register after it has passed four register stages: unpack and
// add, divide by three, axis compare setup, final compare. Reset is synchronous
// and active low; it clears the valid bits and loads the register defaults. A
// stalled output that holds a valid result freezes every stage at once, so the
// input stalls in that same cycle and nothing is lost.
module antialias_edge_pixel_detector #(
    parameter int MAX_DIM = aaedge_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  aaedge_pkg::t_in                    i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output aaedge_pkg::t_out                   o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [aaedge_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [aaedge_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DIM_W > aaedge_pkg::DIM_REG_W) ? DIM_W : aaedge_pkg::DIM_REG_W;
    localparam int LW    = aaedge_pkg::LUMA_W;
    localparam int NPIX  = 5;

    aaedge_pkg::t_cfg  cfg;
    aaedge_pkg::t_out  r_out;
    logic              en;
    logic [CMP_W-1:0]  w_ext;
    logic [CMP_W-1:0]  h_ext;
    logic [CMP_W-1:0]  w_lim;
    logic [CMP_W-1:0]  h_lim;
    logic [CMP_W-1:0]  x_next;
    logic [CMP_W-1:0]  y_next;
    logic              border;
    logic              fmt_ok;
    logic [aaedge_pkg::PIX_W-1:0] words [NPIX];
    logic [LW-1:0]     luma [NPIX];
    logic              blend_h;
    logic              blend_v;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_ov;
    logic              r_bord1;
    logic              r_bord2;
    logic              r_bord3;
    logic              r_fok1;
    logic              r_fok2;
    logic              r_fok3;
    logic              r_fok_o;
    logic              r_bord_o;
    logic [LW-1:0]     r_luma3;

    aaedge_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // The whole pipeline moves unless a finished result is held back.
    assign en          = !r_ov || !i_out_stall;
    assign o_in_stall  = !en;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Border test against the region size, clamped to the largest side.
    assign w_ext  = CMP_W'(cfg.image_width);
    assign h_ext  = CMP_W'(cfg.image_height);
    assign w_lim  = (w_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : w_ext;
    assign h_lim  = (h_ext > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM) : h_ext;
    assign x_next = CMP_W'(i_in_data.pos_x) + CMP_W'(1);
    assign y_next = CMP_W'(i_in_data.pos_y) + CMP_W'(1);
    assign border = (i_in_data.pos_x == '0) || (i_in_data.pos_y == '0)
                    || (x_next >= w_lim) || (y_next >= h_lim);
    assign fmt_ok = cfg.pixel_format <= aaedge_pkg::FMT_GRAY8;

    // Luminance of the centre and its four neighbors.
    assign words[0] = i_in_data.centre_pixel;
    assign words[1] = i_in_data.left_pixel;
    assign words[2] = i_in_data.right_pixel;
    assign words[3] = i_in_data.upper_pixel;
    assign words[4] = i_in_data.lower_pixel;

    for (genvar g = 0; g < NPIX; g++) begin : g_luma
        aaedge_luma u_luma (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_fmt  (cfg.pixel_format),
            .i_word (words[g]),
            .o_luma (luma[g])
        );
    end

    // One compare unit per axis.
    aaedge_axis u_axis_h (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_c     (luma[0]),
        .i_a     (luma[1]),
        .i_b     (luma[2]),
        .i_cfg   (cfg),
        .o_blend (blend_h)
    );

    aaedge_axis u_axis_v (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_c     (luma[0]),
        .i_a     (luma[3]),
        .i_b     (luma[4]),
        .i_cfg   (cfg),
        .o_blend (blend_v)
    );

    // Valid bits travel alongside the data stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // Side flags and the centre luminance, delayed to the output stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bord1  <= border;
            r_fok1   <= fmt_ok;
            r_bord2  <= r_bord1;
            r_fok2   <= r_fok1;
            r_bord3  <= r_bord2;
            r_fok3   <= r_fok2;
            r_luma3  <= luma[0];
            r_bord_o <= r_bord3;
            r_fok_o  <= r_fok3;
            r_out.is_blend_pixel <= r_fok3 && !r_bord3 && (blend_h || blend_v);
            r_out.centre_luma    <= r_luma3;
        end
    end

`ifndef SYNTHESIS
    // A transfer on the input lands in the first stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v1)
        else $error("accepted pixel did not enter the first stage");

    // A held result freezes every stage.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> $stable(r_v1) && $stable(r_v2) && $stable(r_v3))
        else $error("pipeline moved while the output was held");

    // An unsupported format gives an all-zero result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_fok_o |-> (o_out_data.is_blend_pixel == 1'b0)
                             && (o_out_data.centre_luma == '0))
        else $error("unsupported format gave a nonzero result");

    // A border pixel is never reported as a blend.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_bord_o |-> !o_out_data.is_blend_pixel)
        else $error("border pixel reported as blend");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import aaedge_pkg::*;

    // Format and register codes that the package leaves unnamed.
    localparam logic [FMT_W-1:0]     FMT_UNSUPPORTED = 3'd5;
    localparam logic [FMT_W-1:0]     FMT_RESERVED_6  = 3'd6;
    localparam logic [FMT_W-1:0]     FMT_RESERVED_7  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_6  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_7  = 3'd7;

    localparam int PIPE_DRAIN = 16;
    localparam int MAX_GAP    = 18;

    // Kinds of neighborhoods that the random stimulus builds.
    typedef enum int {SHAPE_RAMP, SHAPE_NEAR_LIMIT, SHAPE_HARD, SHAPE_NOISE} t_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Local copy of the register file and the classifications still in flight.
    t_cfg shadow_cfg;
    t_out expected_class[$];

    int error_count       = 0;
    int pixels_sent       = 0;
    int results_checked   = 0;
    int blends_seen       = 0;
    int settings_applied  = 0;
    bit src_idle          = 1'b0;
    bit sink_idle         = 1'b0;
    int long_stall_cycles = 0;

    always #4 i_clk = ~i_clk;

    antialias_edge_pixel_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Luminance of one raw word in the given format; zero for unsupported codes.
    function automatic int luma_of_word(logic [FMT_W-1:0] fmt, logic [PIX_W-1:0] word);
        int r, g, b;
        case (fmt)
            FMT_RGBA8888, FMT_BGRA8888: begin
                r = int'(word[7:0]);
                g = int'(word[15:8]);
                b = int'(word[23:16]);
                return (r + g + b) / 3;
            end
            FMT_RGB565: begin
                r = int'(word[15:11]);
                g = int'(word[10:5]);
                b = int'(word[4:0]);
                r = (r << 3) | (r >> 2);
                g = (g << 2) | (g >> 4);
                b = (b << 3) | (b >> 2);
                return (r + g + b) / 3;
            end
            FMT_ARGB4444: begin
                r = int'(word[15:12]);
                g = int'(word[11:8]);
                b = int'(word[7:4]);
                return ((r + g + b) / 3) * 17;
            end
            FMT_GRAY8: return int'(word[7:0]);
            default: return 0;
        endcase
    endfunction

    // One axis counts as a blend when it straddles a boundary and the center
    // sits clear of both neighbors.
    function automatic bit axis_is_blend(int c, int a, int b);
        int lo, hi, thr, mar, tol, da, db;
        thr = int'(shadow_cfg.edge_threshold);
        mar = int'(shadow_cfg.inner_margin);
        tol = int'(shadow_cfg.hard_edge_tolerance);
        if (((a > b) ? a - b : b - a) <= thr) return 1'b0;
        lo = ((a < b) ? a : b) + mar;
        hi = ((a > b) ? a : b) - mar;
        da = (c > a) ? c - a : a - c;
        db = (c > b) ? c - b : b - c;
        return (c > lo) && (c < hi) && (da > tol) && (db > tol);
    endfunction

    // Expected result for one pixel under the current register settings.
    function automatic t_out classify_pixel(t_in p);
        t_out res;
        int w, h, x, y, c;
        w = (shadow_cfg.image_width > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(shadow_cfg.image_width);
        h = (shadow_cfg.image_height > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(shadow_cfg.image_height);
        x = int'(p.pos_x);
        y = int'(p.pos_y);
        c = 0;
        res.is_blend_pixel = 1'b0;
        if (shadow_cfg.pixel_format <= FMT_GRAY8) begin
            c = luma_of_word(shadow_cfg.pixel_format, p.centre_pixel);
            if (!(x < 1 || y < 1 || x >= w - 1 || y >= h - 1)) begin
                res.is_blend_pixel =
                    axis_is_blend(c, luma_of_word(shadow_cfg.pixel_format, p.left_pixel),
                                  luma_of_word(shadow_cfg.pixel_format, p.right_pixel)) ||
                    axis_is_blend(c, luma_of_word(shadow_cfg.pixel_format, p.upper_pixel),
                                  luma_of_word(shadow_cfg.pixel_format, p.lower_pixel));
            end
        end
        res.centre_luma = c[7:0];
        return res;
    endfunction

    // Raw word whose luminance is close to the target, with random ignored bits.
    function automatic logic [PIX_W-1:0] word_for_luma(logic [FMT_W-1:0] fmt, int lum);
        logic [PIX_W-1:0] junk;
        logic [7:0]       l8, spread;
        int               room;
        if (lum < 0) lum = 0;
        if (lum > 255) lum = 255;
        l8   = lum[7:0];
        junk = $urandom;
        case (fmt)
            FMT_RGB565:   return {junk[31:16], l8[7:3], l8[7:2], l8[7:3]};
            FMT_ARGB4444: return {junk[31:16], l8[7:4], l8[7:4], l8[7:4], junk[3:0]};
            FMT_GRAY8:    return {junk[31:8], l8};
            default: begin
                // Spread the channels apart while keeping their sum.
                room   = (lum < 128) ? lum : 255 - lum;
                spread = 8'($urandom_range(0, room));
                return {junk[31:24], l8 + spread, l8 - spread, l8};
            end
        endcase
    endfunction

    function automatic t_in pixel_from_lumas(int x, int y, int c, int l, int r, int u, int d);
        t_in p;
        p.pos_x        = POS_W'(x);
        p.pos_y        = POS_W'(y);
        p.centre_pixel = word_for_luma(shadow_cfg.pixel_format, c);
        p.left_pixel   = word_for_luma(shadow_cfg.pixel_format, l);
        p.right_pixel  = word_for_luma(shadow_cfg.pixel_format, r);
        p.upper_pixel  = word_for_luma(shadow_cfg.pixel_format, u);
        p.lower_pixel  = word_for_luma(shadow_cfg.pixel_format, d);
        return p;
    endfunction

    // Mostly interior positions, some right on or next to the border.
    function automatic logic [POS_W-1:0] pick_pos(int dim);
        int eff;
        eff = (dim > MAX_DIM_DEF) ? MAX_DIM_DEF : dim;
        case ($urandom_range(0, 9))
            0: return POS_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: return POS_W'(0);
                    1: return POS_W'(1);
                    2: return POS_W'(eff - 2);
                    default: return POS_W'(eff - 1);
                endcase
            end
            default: return (eff >= 3) ? POS_W'($urandom_range(1, eff - 2)) : POS_W'($urandom);
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 7))
            0: return $urandom_range(0, 3);
            1: return $urandom_range(MAX_DIM_DEF + 1, 8191);
            2: return MAX_DIM_DEF;
            3: return $urandom_range(4, MAX_DIM_DEF - 1);
            default: return $urandom_range(8, 96);
        endcase
    endfunction

    function automatic int pick_level(int typical);
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic int draw_gap(bit enabled);
        if (!enabled) return 0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    // Random neighborhood: ramps across one or both axes, cases right at the
    // threshold, margin and tolerance limits, hard edges, and plain noise.
    function automatic t_in build_pixel();
        t_in              p;
        t_shape           shape;
        logic [FMT_W-1:0] fmt;
        int pick, a, b, c, lo, hi, k, axis, thr, mar, tol;
        thr  = int'(shadow_cfg.edge_threshold);
        mar  = int'(shadow_cfg.inner_margin);
        tol  = int'(shadow_cfg.hard_edge_tolerance);
        fmt  = shadow_cfg.pixel_format;
        pick = $urandom_range(0, 9);
        shape = (pick < 5) ? SHAPE_RAMP : (pick < 7) ? SHAPE_NEAR_LIMIT :
                (pick < 8) ? SHAPE_HARD : SHAPE_NOISE;
        if (shape == SHAPE_NOISE) begin
            p.pos_x        = POS_W'($urandom);
            p.pos_y        = POS_W'($urandom);
            p.centre_pixel = $urandom;
            p.left_pixel   = $urandom;
            p.right_pixel  = $urandom;
            p.upper_pixel  = $urandom;
            p.lower_pixel  = $urandom;
            return p;
        end
        a = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
        k = $urandom_range(0, 1);
        case (shape)
            SHAPE_RAMP: c = $urandom_range(a, b);
            SHAPE_NEAR_LIMIT: begin
                b  = (a < 128) ? a + thr + k : a - thr - k;
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                k  = $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0: c = lo + mar + k;
                    1: c = hi - mar - k;
                    2: c = lo + tol + k;
                    default: c = hi - tol - k;
                endcase
            end
            default: begin
                pick = $urandom_range(0, 2 * tol + 2);
                c = ((k != 0) ? a : b) + pick - tol - 1;
            end
        endcase
        p.pos_x        = pick_pos(int'(shadow_cfg.image_width));
        p.pos_y        = pick_pos(int'(shadow_cfg.image_height));
        p.centre_pixel = word_for_luma(fmt, c);
        axis = $urandom_range(0, 2);
        if (axis != 1) begin
            p.left_pixel  = word_for_luma(fmt, a);
            p.right_pixel = word_for_luma(fmt, b);
        end else begin
            p.left_pixel  = word_for_luma(fmt, $urandom_range(0, 255));
            p.right_pixel = word_for_luma(fmt, $urandom_range(0, 255));
        end
        if (axis != 0) begin
            p.upper_pixel = word_for_luma(fmt, b);
            p.lower_pixel = word_for_luma(fmt, a);
        end else begin
            p.upper_pixel = word_for_luma(fmt, $urandom_range(0, 255));
            p.lower_pixel = word_for_luma(fmt, $urandom_range(0, 255));
        end
        return p;
    endfunction

    // Offer one pixel and hold it until the block takes it. Valid stays high
    // after the transfer so that back-to-back pixels need no dead cycle.
    task automatic send_pixel(input t_in pix);
        int gap;
        gap = draw_gap(src_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pix;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expected_class.insert(expected_class.size(), classify_pixel(pix));
        pixels_sent++;
    endtask

    // Drop the input and let every pixel in flight come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_class.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    // One register write; valid stays up so that writes can follow back to back.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_PIXEL_FORMAT:  shadow_cfg.pixel_format        = data[FMT_W-1:0];
            REG_IMAGE_WIDTH:   shadow_cfg.image_width         = data[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT:  shadow_cfg.image_height        = data[DIM_REG_W-1:0];
            REG_BOUNDARY_THR:  shadow_cfg.edge_threshold      = data[THR_W-1:0];
            REG_BLEND_MARGIN:  shadow_cfg.inner_margin        = data[THR_W-1:0];
            REG_HARD_EDGE_TOL: shadow_cfg.hard_edge_tolerance = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Full register set, written once the block is idle. Unused upper data
    // bits are sometimes set, since the block must drop them.
    task automatic apply_settings(int fmt, int w, int h, int thr, int mar, int tol);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
        set_reg(REG_PIXEL_FORMAT, {junk[CFG_DATA_W-1:FMT_W], fmt[FMT_W-1:0]});
        set_reg(REG_IMAGE_WIDTH, w[CFG_DATA_W-1:0]);
        set_reg(REG_IMAGE_HEIGHT, h[CFG_DATA_W-1:0]);
        set_reg(REG_BOUNDARY_THR, {junk[CFG_DATA_W-1:THR_W], thr[THR_W-1:0]});
        set_reg(REG_BLEND_MARGIN, {junk[CFG_DATA_W-1:THR_W], mar[THR_W-1:0]});
        set_reg(REG_HARD_EDGE_TOL, {junk[CFG_DATA_W-1:THR_W], tol[THR_W-1:0]});
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // Thresholds keep their reset values; only the region size is written.
    task automatic test_reset_defaults();
        send_pixel(pixel_from_lumas(5, 5, 100, 50, 150, 100, 100));
        wait_idle();
        set_reg(REG_IMAGE_WIDTH, 13'd64);
        set_reg(REG_IMAGE_HEIGHT, 13'd64);
        i_cfg_valid <= 1'b0;
        settings_applied++;
        send_pixel(pixel_from_lumas(5, 5, 100, 50, 150, 100, 100));
        send_pixel(pixel_from_lumas(6, 7, 52, 50, 150, 100, 100));
    endtask

    // A clear blend and an all-ones neighborhood in each format, then the
    // unsupported codes.
    task automatic test_formats();
        t_in ones;
        ones = '1;
        ones.pos_x = POS_W'(1);
        ones.pos_y = POS_W'(1);
        for (int f = FMT_RGBA8888; f <= FMT_GRAY8; f++) begin
            apply_settings(f, 32, 32, int'(RST_BOUNDARY_THR), int'(RST_BLEND_MARGIN),
                           int'(RST_HARD_EDGE_TOL));
            send_pixel(pixel_from_lumas(10, 10, 120, 40, 220, 120, 120));
            send_pixel(ones);
        end
        apply_settings(FMT_UNSUPPORTED, 32, 32, 10, 2, 3);
        send_pixel(pixel_from_lumas(10, 10, 120, 40, 220, 120, 120));
        apply_settings(FMT_RESERVED_6, 32, 32, 10, 2, 3);
        send_pixel(pixel_from_lumas(11, 9, 100, 20, 200, 100, 100));
        apply_settings(FMT_RESERVED_7, 32, 32, 10, 2, 3);
        send_pixel(pixel_from_lumas(12, 3, 90, 220, 10, 90, 90));
    endtask

    // Each border with an oversized region, then a region one pixel wide.
    task automatic test_borders();
        apply_settings(FMT_GRAY8, 8191, 8191, 10, 2, 3);
        send_pixel(pixel_from_lumas(0, 100, 100, 20, 200, 20, 200));
        send_pixel(pixel_from_lumas(100, 0, 100, 20, 200, 20, 200));
        send_pixel(pixel_from_lumas(4095, 100, 100, 20, 200, 20, 200));
        send_pixel(pixel_from_lumas(100, 4095, 100, 20, 200, 20, 200));
        send_pixel(pixel_from_lumas(4094, 4094, 100, 20, 200, 20, 200));
        send_pixel('0);
        apply_settings(FMT_GRAY8, 1, MAX_DIM_DEF, 10, 2, 3);
        send_pixel(pixel_from_lumas(2, 2, 100, 20, 200, 20, 200));
    endtask

    // All limits at zero, writes to unmapped indexes, then all limits at full scale.
    task automatic test_threshold_extremes();
        apply_settings(FMT_RGBA8888, 16, 16, 0, 0, 0);
        send_pixel(pixel_from_lumas(3, 3, 1, 0, 0, 0, 2));
        wait_idle();
        set_reg(REG_UNMAPPED_6, '1);
        set_reg(REG_UNMAPPED_7, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        send_pixel(pixel_from_lumas(4, 4, 1, 2, 0, 0, 0));
        apply_settings(FMT_RGBA8888, 16, 16, 255, 255, 255);
        send_pixel(pixel_from_lumas(5, 5, 128, 0, 255, 0, 255));
    endtask

    // The output holds off for a long stretch while pixels keep coming, so the
    // pipeline fills and the input stalls.
    task automatic test_backpressure();
        apply_settings(FMT_RGBA8888, 64, 64, 10, 2, 3);
        src_idle          = 1'b0;
        sink_idle         = 1'b0;
        long_stall_cycles = 250;
        repeat (48) send_pixel(build_pixel());
    endtask

    // Random settings, each held for a run of random pixels.
    task automatic test_random_phases(int phases, int per_phase);
        int fmt;
        for (int p = 0; p < phases; p++) begin
            fmt = ($urandom_range(0, 9) == 0) ? $urandom_range(FMT_UNSUPPORTED, FMT_RESERVED_7)
                                              : $urandom_range(FMT_RGBA8888, FMT_GRAY8);
            apply_settings(fmt, pick_dim(), pick_dim(), pick_level(40), pick_level(12),
                           pick_level(12));
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            repeat (per_phase) send_pixel(build_pixel());
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (expected_class.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (expected_class.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_class.size());
            error_count += expected_class.size();
        end
        $display("Sent %0d pixels and checked %0d results (%0d blends) over %0d settings.",
                 pixels_sent, results_checked, blends_seen, settings_applied);
        $display("Run covered all formats, unsupported codes, borders, oversized regions,");
        $display("limit extremes, unmapped writes and a long output stall.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    endtask

    // Stimulus sequence.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_PIXEL_FORMAT;
        i_cfg_data  <= '0;
        shadow_cfg = '{pixel_format: FMT_RGBA8888, image_width: '0, image_height: '0,
                       edge_threshold: RST_BOUNDARY_THR, inner_margin: RST_BLEND_MARGIN,
                       hard_edge_tolerance: RST_HARD_EDGE_TOL};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        test_reset_defaults();
        test_formats();
        test_borders();
        test_threshold_extremes();
        test_backpressure();
        test_random_phases(12, 132);
        finish_run();
    end

    // Output side: random stalls per result, plus the long hold when requested.
    initial begin : result_sink
        int hold;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_stall_cycles > 0) begin
                hold = long_stall_cycles;
                long_stall_cycles = 0;
            end else begin
                hold = draw_gap(sink_idle);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    // Compare every result transfer with the oldest pending classification.
    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_class.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual blend %b luma %0d",
                         $time, o_out_data.is_blend_pixel, o_out_data.centre_luma);
                error_count++;
            end else begin
                want = expected_class.pop_front();
                results_checked++;
                if (want.is_blend_pixel) blends_seen++;
                if (o_out_data.is_blend_pixel !== want.is_blend_pixel) begin
                    $display("%0t: is_blend_pixel mismatch, expected %b, actual %b",
                             $time, want.is_blend_pixel, o_out_data.is_blend_pixel);
                    error_count++;
                end
                if (o_out_data.centre_luma !== want.centre_luma) begin
                    $display("%0t: centre_luma mismatch, expected %0d, actual %0d",
                             $time, want.centre_luma, o_out_data.centre_luma);
                    error_count++;
                end
            end
        end
    end

    // Hard stop in case the handshakes hang.
    initial begin
        #4000000;
        $display("%0t: run timed out", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/aaedge_pkg.sv
rtl/aaedge_cfg.sv
rtl/aaedge_luma.sv
rtl/aaedge_axis.sv
rtl/antialias_edge_pixel_detector.sv
verif/testbench.sv
